// ===== hw/rtl/hashed_noise_sampler_1d_macros.svh =====
// Assertion macros for the hashed noise sampler.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef HASHED_NOISE_SAMPLER_1D_MACROS_SVH
`define HASHED_NOISE_SAMPLER_1D_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define HNS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hns1d check failed");
// Next-cycle implication, disabled during reset
`define HNS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hns1d check failed");
`else
`define HNS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HNS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/hns1d_pkg.sv =====
// Shared constants for the hashed noise sampler: field widths, hash multipliers
// and mode codes. No dependencies.
`timescale 1ns / 1ps

package hns1d_pkg;

   // Word field widths
   localparam int COORD_W = 32;
   localparam int SEED_W  = 32;
   localparam int NOISE_W = 25;
   localparam int MODE_W  = 2;

   // Default number of fraction bits in the coordinate
   localparam int FRAC_BITS_DEFAULT = 16;

   // Hash mixing multipliers
   localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

   // Mode codes; any other code selects gradient noise
   localparam logic [MODE_W-1:0] NOISE_MODE_WHITE  = 2'd0;
   localparam logic [MODE_W-1:0] NOISE_MODE_VALUE  = 2'd1;
   localparam logic [MODE_W-1:0] NOISE_MODE_PERLIN = 2'd2;

   // Output range, units of 2^-23
   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 25'sd8388608;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = -25'sd8388608;

endpackage

// ===== hw/rtl/hns1d_req_if.sv =====
// Request channel: one coordinate and seed word per handshake.
// Depends on hns1d_pkg for the field widths.
`timescale 1ns / 1ps

interface hns1d_req_if
   import hns1d_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coord;
   logic        [SEED_W-1:0]  seed_word;

   modport source (output valid, output coord, output seed_word, input ready);
   modport sink   (input valid, input coord, input seed_word, output ready);
endinterface

// ===== hw/rtl/hns1d_rsp_if.sv =====
// Response channel: one noise sample per handshake.
// Depends on hns1d_pkg for the field width.
`timescale 1ns / 1ps

interface hns1d_rsp_if
   import hns1d_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_out;

   modport source (output valid, output noise_out, input ready);
   modport sink   (input valid, input noise_out, output ready);
endinterface

// ===== hw/rtl/hashed_noise_sampler_1d.sv =====
// One-dimensional hashed noise sampler. Each request word carries a signed
// fixed-point coordinate (FRAC_BITS fraction bits) and a seed; the response
// word is one sample in units of 2^-23, in -1..1. csr_wr_data selects white,
// value or gradient noise and should only be written while no word is in
// flight. Throughput is one word per clock while rsp_chan.ready is high; the
// pipe has six register stages set by the two multiply rounds of the hash and
// the two rounds of interpolation multipliers. Each stage carries a valid bit
// and fills bubbles on its own, so requests keep flowing while a response
// waits until the whole pipe is full.
// Depends on hns1d_pkg, hns1d_req_if, hns1d_rsp_if and the assertion macros.
`timescale 1ns / 1ps
`include "hashed_noise_sampler_1d_macros.svh"

module hashed_noise_sampler_1d
   import hns1d_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   hns1d_req_if.sink         req_chan,
   hns1d_rsp_if.source       rsp_chan,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   localparam int NUM_STAGES = 6;
   localparam int F   = FRAC_BITS;
   localparam int SQW = 2 * F;          // t * t
   localparam int WPW = 2 * F + 2;      // sq * (3 - 2t)
   localparam int GPW = 24 + F + 1;     // hash * (t or t - 1)
   localparam int PPW = 26 + F + 2;     // gradient delta * w
   localparam int VPW = 25 + F + 2;     // value delta * w
   localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;

   // ---------------------------------------------------------------
   // Mode register
   // ---------------------------------------------------------------
   logic [MODE_W-1:0] noise_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_mode_ff <= NOISE_MODE_PERLIN;
      end else if (csr_wr_en) begin
         noise_mode_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // Stage valid bits and load enables
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] ld;

   // Load a stage when it is empty or its content moves on
   always_comb begin
      ld[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | rsp_chan.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ld[i] = ~vld_ff[i] | ld[i+1];
      end
   end

   always_comb begin
      vld_in[0] = ld[0] ? req_chan.valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = ld[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = ld[0];

   // ---------------------------------------------------------------
   // Stage 1: split coordinate, form hash keys, square fraction
   // ---------------------------------------------------------------
   logic signed [COORD_W-1:0] cell_idx;
   logic [31:0]    s1_k0_in, s1_k1_in, s1_k0_ff, s1_k1_ff;
   logic [F-1:0]   s1_t_in, s1_t_ff;
   logic [SQW-1:0] t_sq;
   logic [F-1:0]   s1_sq_in, s1_sq_ff;

   always_comb begin
      cell_idx = req_chan.coord >>> F;
      s1_k0_in = $unsigned(cell_idx) + req_chan.seed_word;
      s1_k1_in = s1_k0_in + 32'd1;
      s1_t_in  = req_chan.coord[F-1:0];
      t_sq     = SQW'(s1_t_in) * SQW'(s1_t_in);
      s1_sq_in = t_sq[SQW-1:F];
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s1_k0_ff <= s1_k0_in;
         s1_k1_ff <= s1_k1_in;
         s1_t_ff  <= s1_t_in;
         s1_sq_ff <= s1_sq_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: first hash round, smoothstep weight
   // ---------------------------------------------------------------
   logic [31:0]    x0, x1;
   logic [63:0]    p1a, p1b;
   logic [31:0]    s2_ma_in, s2_mb_in, s2_ma_ff, s2_mb_ff;
   logic [F+1:0]   fac;
   logic [WPW-1:0] w_prod;
   logic [F:0]     s2_w_in, s2_w_ff;
   logic [F-1:0]   s2_t_ff;

   always_comb begin
      x0       = s1_k0_ff ^ (s1_k0_ff >> 16);
      x1       = s1_k1_ff ^ (s1_k1_ff >> 16);
      p1a      = 64'(x0) * 64'(HASH_MUL_A);
      p1b      = 64'(x1) * 64'(HASH_MUL_A);
      s2_ma_in = p1a[31:0];
      s2_mb_in = p1b[31:0];
      fac      = THREE_ONE - (F + 2)'({s1_t_ff, 1'b0});
      w_prod   = WPW'(s1_sq_ff) * WPW'(fac);
      s2_w_in  = w_prod[2*F:F];
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s2_ma_ff <= s2_ma_in;
         s2_mb_ff <= s2_mb_in;
         s2_w_ff  <= s2_w_in;
         s2_t_ff  <= s1_t_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: second hash round
   // ---------------------------------------------------------------
   logic [31:0]  y0, y1;
   logic [63:0]  p2a, p2b;
   logic [31:0]  s3_ma_in, s3_mb_in, s3_ma_ff, s3_mb_ff;
   logic [F:0]   s3_w_ff;
   logic [F-1:0] s3_t_ff;

   always_comb begin
      y0       = s2_ma_ff ^ (s2_ma_ff >> 15);
      y1       = s2_mb_ff ^ (s2_mb_ff >> 15);
      p2a      = 64'(y0) * 64'(HASH_MUL_B);
      p2b      = 64'(y1) * 64'(HASH_MUL_B);
      s3_ma_in = p2a[31:0];
      s3_mb_in = p2b[31:0];
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s3_ma_ff <= s3_ma_in;
         s3_mb_ff <= s3_mb_in;
         s3_w_ff  <= s2_w_ff;
         s3_t_ff  <= s2_t_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: finish hashes, map to signed, gradient products
   // ---------------------------------------------------------------
   logic [31:0]        h0, h1;
   logic signed [23:0] hash_a, hash_b;
   logic signed [F:0]  t_pos, t_neg;
   logic signed [GPW-1:0] ga_prod, gb_prod;
   logic signed [23:0] s4_a_ff;
   logic signed [24:0] s4_ga_in, s4_gb_in, s4_dab_in;
   logic signed [24:0] s4_ga_ff, s4_gb_ff, s4_dab_ff;
   logic [F:0]         s4_w_ff;

   always_comb begin
      h0        = s3_ma_ff ^ (s3_ma_ff >> 16);
      h1        = s3_mb_ff ^ (s3_mb_ff >> 16);
      // low 24 bits minus 2^23: flip the top bit, read as signed
      hash_a    = $signed({~h0[23], h0[22:0]});
      hash_b    = $signed({~h1[23], h1[22:0]});
      t_pos     = $signed({1'b0, s3_t_ff});
      t_neg     = $signed({1'b1, s3_t_ff});   // t - 1
      ga_prod   = GPW'(hash_a) * GPW'(t_pos);
      gb_prod   = GPW'(hash_b) * GPW'(t_neg);
      s4_ga_in  = 25'(ga_prod >>> F);
      s4_gb_in  = 25'(gb_prod >>> F);
      s4_dab_in = 25'(hash_b) - 25'(hash_a);
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s4_a_ff   <= hash_a;
         s4_ga_ff  <= s4_ga_in;
         s4_gb_ff  <= s4_gb_in;
         s4_dab_ff <= s4_dab_in;
         s4_w_ff   <= s3_w_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: weighted deltas for value and gradient blends
   // ---------------------------------------------------------------
   logic signed [25:0]    g_diff;
   logic signed [F+1:0]   w_s;
   logic signed [PPW-1:0] gd_prod;
   logic signed [VPW-1:0] vd_prod;
   logic signed [25:0]    s5_gterm_in, s5_gterm_ff;
   logic signed [24:0]    s5_vterm_in, s5_vterm_ff, s5_ga_ff;
   logic signed [23:0]    s5_a_ff;

   always_comb begin
      g_diff      = 26'(s4_gb_ff) - 26'(s4_ga_ff);
      w_s         = $signed({1'b0, s4_w_ff});
      gd_prod     = PPW'(g_diff) * PPW'(w_s);
      vd_prod     = VPW'(s4_dab_ff) * VPW'(w_s);
      s5_gterm_in = 26'(gd_prod >>> F);
      s5_vterm_in = 25'(vd_prod >>> F);
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s5_gterm_ff <= s5_gterm_in;
         s5_vterm_ff <= s5_vterm_in;
         s5_ga_ff    <= s4_ga_ff;
         s5_a_ff     <= s4_a_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: select by mode, double and clamp gradient, output register
   // ---------------------------------------------------------------
   logic signed [25:0]        val_sum;
   logic signed [26:0]        grad_sum;
   logic signed [27:0]        grad_dbl;
   logic signed [NOISE_W-1:0] grad_out;
   logic signed [NOISE_W-1:0] noise_in, noise_ff;

   always_comb begin
      val_sum  = 26'(s5_a_ff) + 26'(s5_vterm_ff);
      grad_sum = 27'(s5_ga_ff) + 27'(s5_gterm_ff);
      grad_dbl = $signed({grad_sum, 1'b0});
      if (grad_dbl > 28'(NOISE_MAX)) begin
         grad_out = NOISE_MAX;
      end else if (grad_dbl < 28'(NOISE_MIN)) begin
         grad_out = NOISE_MIN;
      end else begin
         grad_out = 25'(grad_dbl);
      end
      case (noise_mode_ff)
         NOISE_MODE_WHITE: begin
            noise_in = 25'(s5_a_ff);
         end
         NOISE_MODE_VALUE: begin
            noise_in = 25'(val_sum);
         end
         default: begin
            noise_in = grad_out;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_chan.valid     = vld_ff[NUM_STAGES-1];
   assign rsp_chan.noise_out = noise_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `HNS_ASSERT_NXT(a_accept_fills_s1, clock, reset, req_chan.valid && req_chan.ready, vld_ff[0])
   `HNS_ASSERT_IMP(a_stall_only_full, clock, reset, !req_chan.ready, &vld_ff)
   `HNS_ASSERT_IMP(a_out_range, clock, reset, rsp_chan.valid,
      (rsp_chan.noise_out >= NOISE_MIN) && (rsp_chan.noise_out <= NOISE_MAX))
   `HNS_ASSERT_IMP(a_white_below_one, clock, reset,
      rsp_chan.valid && (noise_mode_ff == NOISE_MODE_WHITE), rsp_chan.noise_out != NOISE_MAX)

endmodule

// ===== tb/hashed_noise_sampler_1d_checker.sv =====
// Checker for the hashed noise sampler: watches the request, response and csr
// ports, predicts each noise sample and compares it with the response word.
// Depends on hns1d_pkg, hns1d_req_if and hns1d_rsp_if.
`timescale 1ns / 1ps

module hashed_noise_sampler_1d_checker
   import hns1d_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data,
   hns1d_req_if              req_mon,
   hns1d_rsp_if              rsp_mon,
   output int                mismatch_count,
   output int                words_pending
);

   typedef struct {
      logic [COORD_W-1:0]        coord;
      logic [SEED_W-1:0]         seed;
      logic signed [NOISE_W-1:0] sample;
   } sample_entry_type;

   sample_entry_type  expected_samples[$];
   logic [MODE_W-1:0] mode_shadow;

   // Mix one key and map its low 24 bits to -2^23..2^23-1
   function automatic longint mix_key(input logic [31:0] key);
      logic [31:0] h;
      h = key;
      h ^= h >> 16;
      h = h * HASH_MUL_A;
      h ^= h >> 15;
      h = h * HASH_MUL_B;
      h ^= h >> 16;
      return longint'({8'd0, h[23:0]}) - 64'sd8388608;
   endfunction

   // Compute the sample for one coordinate, seed and mode
   function automatic logic signed [NOISE_W-1:0] predict_sample(
      input logic [COORD_W-1:0] coord,
      input logic [SEED_W-1:0]  seed,
      input logic [MODE_W-1:0]  mode
   );
      logic signed [31:0] cell_idx;
      logic [31:0]        key_lo;
      longint             one, t, a, b, sq, w, ga, gb, r;
      one      = longint'(1) << FRAC_BITS;
      cell_idx = $signed(coord) >>> FRAC_BITS;
      key_lo   = cell_idx + seed;
      t        = longint'(coord) & (one - 1);
      a        = mix_key(key_lo);
      b        = mix_key(key_lo + 32'd1);
      sq       = (t * t) >>> FRAC_BITS;
      w        = (sq * (3 * one - 2 * t)) >>> FRAC_BITS;
      case (mode)
         NOISE_MODE_WHITE: begin
            r = a;
         end
         NOISE_MODE_VALUE: begin
            r = a + (((b - a) * w) >>> FRAC_BITS);
         end
         default: begin
            ga = (a * t) >>> FRAC_BITS;
            gb = (b * (t - one)) >>> FRAC_BITS;
            r  = 2 * (ga + (((gb - ga) * w) >>> FRAC_BITS));
            if (r > longint'(NOISE_MAX)) r = longint'(NOISE_MAX);
            if (r < longint'(NOISE_MIN)) r = longint'(NOISE_MIN);
         end
      endcase
      return r[NOISE_W-1:0];
   endfunction

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
      mode_shadow    = NOISE_MODE_PERLIN;
   end

   // Track the mode, queue predictions on request words, check response words
   always @(posedge clock) begin
      sample_entry_type entry;
      if (reset) begin
         mode_shadow = NOISE_MODE_PERLIN;
         expected_samples.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response word, noise_out %0d",
                        $time, rsp_mon.noise_out);
            end else begin
               entry = expected_samples.pop_front();
               if (rsp_mon.noise_out !== entry.sample) begin
                  mismatch_count++;
                  $display("%0t: noise_out mismatch coord %h seed %h: expected %0d, got %0d",
                           $time, entry.coord, entry.seed, entry.sample, rsp_mon.noise_out);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            entry.coord  = req_mon.coord;
            entry.seed   = req_mon.seed_word;
            entry.sample = predict_sample(req_mon.coord, req_mon.seed_word, mode_shadow);
            expected_samples.push_back(entry);
         end
         if (csr_wr_en) begin
            mode_shadow = csr_wr_data;
         end
      end
      words_pending = expected_samples.size();
   end

endmodule

// ===== tb/hashed_noise_sampler_1d_tb.sv =====
// Testbench top for the hashed noise sampler: clock, reset, csr writes and
// request/response traffic with random idling; the checker does the compare.
// Depends on hns1d_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module hashed_noise_sampler_1d_tb;
   import hns1d_pkg::*;

   localparam int FRAC_BITS       = FRAC_BITS_DEFAULT;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PER_MODE = 65;
   localparam int DRAIN_CYCLES    = 20;

   // Code 3 is not named in the package; the block treats it as gradient noise
   localparam logic [MODE_W-1:0] NOISE_MODE_ALIAS = 2'd3;

   localparam logic [MODE_W-1:0] PHASE_MODE [0:7] = '{
      NOISE_MODE_PERLIN, NOISE_MODE_WHITE, NOISE_MODE_VALUE, NOISE_MODE_ALIAS,
      NOISE_MODE_PERLIN, NOISE_MODE_VALUE, NOISE_MODE_WHITE, NOISE_MODE_ALIAS
   };

   // Edge coordinates: range ends, zero, minus one, integer point, half cell;
   // some seeds chosen so that cell plus one plus seed wraps
   localparam logic [31:0] DIR_COORD [0:5] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
      32'hffff_ffff, 32'h0001_0000, 32'h0000_8000
   };
   localparam logic [31:0] DIR_SEED [0:5] = '{
      32'h0000_0000, 32'hffff_8000, 32'h0000_0000,
      32'hffff_ffff, 32'h1234_5678, 32'hffff_ffff
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;
   int                mismatch_count;
   int                words_pending;
   int                cycle_count = 0;
   int                send_run = 0;
   int                take_run = 0;

   hns1d_req_if req_if ();
   hns1d_rsp_if rsp_if ();

   hashed_noise_sampler_1d #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hashed_noise_sampler_1d_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Draw a random wait, with occasional runs of back-to-back words
   function automatic int draw_wait(ref int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 5) == 0) begin
         run_left = $urandom_range(5, 20);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Pick a random coordinate and seed, biased toward edges of the cell math
   task automatic pick_random_word(output logic [31:0] coord, output logic [31:0] seed);
      logic [31:0]        frac_mask;
      logic [31:0]        raw;
      logic signed [31:0] cell_idx;
      frac_mask = (32'd1 << FRAC_BITS) - 32'd1;
      raw       = $urandom;
      coord     = $urandom;
      seed      = $urandom;
      case ($urandom_range(0, 5))
         0: ;
         1: coord = {{12{raw[19]}}, raw[19:0]};
         2: begin
            coord = coord & ~frac_mask;
            case ($urandom_range(0, 3))
               0: ;
               1: coord = coord | frac_mask;
               2: coord = coord | 32'd1;
               default: coord = coord | (frac_mask - 32'd1);
            endcase
         end
         3: begin
            cell_idx = $signed(coord) >>> FRAC_BITS;
            seed     = ~cell_idx;
         end
         4: coord = raw[0] ? 32'h7fff_ffff - raw[15:8] : 32'h8000_0000 + raw[15:8];
         default: seed = raw[0] ? 32'hffff_ffff : 32'h0000_0000;
      endcase
   endtask

   // Offer one request word and hold it until accepted
   task automatic send_word(input logic [31:0] coord, input logic [31:0] seed);
      int gap;
      gap = draw_wait(send_run);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.coord     <= coord;
      req_if.seed_word <= seed;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every expected sample has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Response side: stall a random number of cycles before each word
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         gap = draw_wait(take_run);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // Request side: directed words in the first four phases, then random words; eight phases, each mode twice
   initial begin
      logic [31:0] coord;
      logic [31:0] seed;
      req_if.valid     = 1'b0;
      req_if.coord     = '0;
      req_if.seed_word = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = NOISE_MODE_PERLIN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 8; phase++) begin
         if (phase > 0) begin
            wait_idle();
            write_mode(PHASE_MODE[phase]);
         end
         if (phase < 4) begin
            for (int i = 0; i < 6; i++) begin
               send_word(DIR_COORD[i], DIR_SEED[i]);
            end
         end
         for (int i = 0; i < RANDOM_PER_MODE; i++) begin
            pick_random_word(coord, seed);
            send_word(coord, seed);
         end
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
